/* sv/imc_pkg.sv */
package imc_pkg;

  // Field widths of the pixel and coordinate payloads.
  localparam int CHANNEL_BITS = 8;
  localparam int COORD_BITS   = 12;

  // Widths of the configuration registers.
  localparam int MODE_BITS = 3;
  localparam int DIM_BITS  = 13;
  localparam int OFS_BITS  = 13;

  // Signed width that holds any coordinate, dimension or shifted coordinate.
  localparam int SUM_BITS = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 2;

  // Signed width of a raw channel result before saturation.
  localparam int RAW_BITS = 2 * CHANNEL_BITS + 2;

  // Combine modes.
  localparam logic [MODE_BITS-1:0] MODE_MASK     = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_INV_MASK = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_ADD      = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_SUB      = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_MUL      = 3'd4;

  // Register indexes on the configuration port.
  localparam int REG_IDX_BITS = 3;
  localparam logic [REG_IDX_BITS-1:0] REG_COMBINE_MODE = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_COLOR_MODE   = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_DEST_WIDTH   = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_DEST_HEIGHT  = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_MASK_WIDTH   = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_MASK_HEIGHT  = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_X_OFFSET     = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_Y_OFFSET     = 3'd7;

  localparam int ADDR_BITS = REG_IDX_BITS + 2;

  // Reset value of the size registers.
  localparam logic [DIM_BITS-1:0] DIM_RESET = 13'd4096;

  // One input transaction: mask pixel position, destination and mask pixels.
  typedef struct packed {
    logic [COORD_BITS-1:0]   column;
    logic [COORD_BITS-1:0]   row;
    logic [CHANNEL_BITS-1:0] dest_red;
    logic [CHANNEL_BITS-1:0] dest_green;
    logic [CHANNEL_BITS-1:0] dest_blue;
    logic [CHANNEL_BITS-1:0] mask_red;
    logic [CHANNEL_BITS-1:0] mask_green;
    logic [CHANNEL_BITS-1:0] mask_blue;
  } pix_in_t;

  // One result transaction: write flag, destination position and new pixel.
  typedef struct packed {
    logic                    write_enable;
    logic [COORD_BITS-1:0]   dest_column;
    logic [COORD_BITS-1:0]   dest_row;
    logic [CHANNEL_BITS-1:0] out_red;
    logic [CHANNEL_BITS-1:0] out_green;
    logic [CHANNEL_BITS-1:0] out_blue;
  } pix_out_t;

endpackage

/* sv/image_mask_combine.sv */
// Channel   Ports                                          Transfer
// input     start, busy, pixel_in                          start high while busy low
// result    result_valid, result                           one-cycle strobe, no back-pressure
// config    psel, penable, pwrite, paddr, pwdata,          APB write, pready always high
//           prdata, pready
//
// The result strobe of a transaction is registered through the stages below, and a new
// transaction may be accepted every cycle: busy is never raised.
// There are three register stages: offset add and size checks with the raw
// channel arithmetic, then the shifted-position checks with the channel clamp, then
// the output register. Synchronous reset clears the valid bits and the config registers.
// The receiver cannot stall, so a result is presented for exactly one cycle.
module image_mask_combine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  imc_pkg::pix_in_t               pixel_in,
  output logic                           result_valid,
  output imc_pkg::pix_out_t              result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [imc_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import imc_pkg::*;

  // Configuration registers.
  logic [MODE_BITS-1:0] combine_mode;
  logic                 color_mode;
  logic [DIM_BITS-1:0]  dest_width;
  logic [DIM_BITS-1:0]  dest_height;
  logic [DIM_BITS-1:0]  mask_width;
  logic [DIM_BITS-1:0]  mask_height;
  logic [OFS_BITS-1:0]  x_offset;
  logic [OFS_BITS-1:0]  y_offset;

  logic                    cfg_write;
  logic [REG_IDX_BITS-1:0] reg_idx;

  assign pready    = 1'b1;
  assign busy      = 1'b0;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = paddr[ADDR_BITS-1:2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      combine_mode <= MODE_MASK;
      color_mode   <= 1'b0;
      dest_width   <= DIM_RESET;
      dest_height  <= DIM_RESET;
      mask_width   <= DIM_RESET;
      mask_height  <= DIM_RESET;
      x_offset     <= '0;
      y_offset     <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_COMBINE_MODE: combine_mode <= pwdata[MODE_BITS-1:0];
        REG_COLOR_MODE:   color_mode   <= pwdata[0];
        REG_DEST_WIDTH:   dest_width   <= pwdata[DIM_BITS-1:0];
        REG_DEST_HEIGHT:  dest_height  <= pwdata[DIM_BITS-1:0];
        REG_MASK_WIDTH:   mask_width   <= pwdata[DIM_BITS-1:0];
        REG_MASK_HEIGHT:  mask_height  <= pwdata[DIM_BITS-1:0];
        REG_X_OFFSET:     x_offset     <= pwdata[OFS_BITS-1:0];
        REG_Y_OFFSET:     y_offset     <= pwdata[OFS_BITS-1:0];
        default:          ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (reg_idx)
      REG_COMBINE_MODE: prdata = 32'(combine_mode);
      REG_COLOR_MODE:   prdata = 32'(color_mode);
      REG_DEST_WIDTH:   prdata = 32'(dest_width);
      REG_DEST_HEIGHT:  prdata = 32'(dest_height);
      REG_MASK_WIDTH:   prdata = 32'(mask_width);
      REG_MASK_HEIGHT:  prdata = 32'(mask_height);
      REG_X_OFFSET:     prdata = 32'(x_offset);
      REG_Y_OFFSET:     prdata = 32'(y_offset);
      default:          prdata = '0;
    endcase
  end

  // Signed views of the coordinates, sizes and offsets.
  logic signed [SUM_BITS-1:0] col_s;
  logic signed [SUM_BITS-1:0] row_s;
  logic signed [SUM_BITS-1:0] dw_s;
  logic signed [SUM_BITS-1:0] dh_s;
  logic signed [SUM_BITS-1:0] mw_s;
  logic signed [SUM_BITS-1:0] mh_s;
  logic signed [SUM_BITS-1:0] xo_s;
  logic signed [SUM_BITS-1:0] yo_s;

  assign col_s = $signed(SUM_BITS'(pixel_in.column));
  assign row_s = $signed(SUM_BITS'(pixel_in.row));
  assign dw_s  = $signed(SUM_BITS'(dest_width));
  assign dh_s  = $signed(SUM_BITS'(dest_height));
  assign mw_s  = $signed(SUM_BITS'(mask_width));
  assign mh_s  = $signed(SUM_BITS'(mask_height));
  assign xo_s  = SUM_BITS'($signed(x_offset));
  assign yo_s  = SUM_BITS'($signed(y_offset));

  // Stage one: shift the position and check it against both image sizes.
  logic                       v1;
  logic                       ok1;
  logic signed [SUM_BITS-1:0] dc1;
  logic signed [SUM_BITS-1:0] dr1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    ok1 <= (col_s < dw_s) && (row_s < dh_s) && (col_s < mw_s) && (row_s < mh_s);
    dc1 <= col_s + xo_s;
    dr1 <= row_s + yo_s;
  end

  // Stage two: the shifted position must be non-negative, fit the coordinate
  // width and lie inside the destination.
  logic                  v2;
  logic                  ok2;
  logic [COORD_BITS-1:0] dc2;
  logic [COORD_BITS-1:0] dr2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    ok2 <= ok1
        && (dc1[SUM_BITS-1:COORD_BITS] == '0) && (dr1[SUM_BITS-1:COORD_BITS] == '0)
        && (dc1 < dw_s) && (dr1 < dh_s);
    dc2 <= dc1[COORD_BITS-1:0];
    dr2 <= dr1[COORD_BITS-1:0];
  end

  // Channel units; green and blue pass through in gray mode.
  logic [CHANNEL_BITS-1:0] sat_red;
  logic [CHANNEL_BITS-1:0] sat_green;
  logic [CHANNEL_BITS-1:0] sat_blue;

  imc_chan u_chan_red (
    .clk    (clk),
    .mode   (combine_mode),
    .bypass (1'b0),
    .d      (pixel_in.dest_red),
    .m      (pixel_in.mask_red),
    .sat    (sat_red)
  );

  imc_chan u_chan_green (
    .clk    (clk),
    .mode   (combine_mode),
    .bypass (!color_mode),
    .d      (pixel_in.dest_green),
    .m      (pixel_in.mask_green),
    .sat    (sat_green)
  );

  imc_chan u_chan_blue (
    .clk    (clk),
    .mode   (combine_mode),
    .bypass (!color_mode),
    .d      (pixel_in.dest_blue),
    .m      (pixel_in.mask_blue),
    .sat    (sat_blue)
  );

  // Stage three: output register; an invalid position gives an all-zero result.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    result.write_enable <= ok2;
    result.dest_column  <= ok2 ? dc2 : '0;
    result.dest_row     <= ok2 ? dr2 : '0;
    result.out_red      <= ok2 ? sat_red : '0;
    result.out_green    <= ok2 ? sat_green : '0;
    result.out_blue     <= ok2 ? sat_blue : '0;
  end

endmodule

/* sv/imc_chan.sv */
module imc_chan (
  input  logic                                clk,
  input  logic [imc_pkg::MODE_BITS-1:0]       mode,
  input  logic                                bypass,
  input  logic [imc_pkg::CHANNEL_BITS-1:0]    d,
  input  logic [imc_pkg::CHANNEL_BITS-1:0]    m,
  output logic [imc_pkg::CHANNEL_BITS-1:0]    sat
);
  import imc_pkg::*;

  localparam logic signed [RAW_BITS-1:0] CH_MAX =
    $signed(RAW_BITS'((1 << CHANNEL_BITS) - 1));

  logic signed [RAW_BITS-1:0] raw_next;
  logic signed [RAW_BITS-1:0] raw;
  logic signed [RAW_BITS-1:0] d_ext;
  logic signed [RAW_BITS-1:0] m_ext;

  assign d_ext = $signed(RAW_BITS'(d));
  assign m_ext = $signed(RAW_BITS'(m));

  // First stage: apply the combine mode, or pass d through when bypassed, without any clamping.
  always_comb begin
    if (bypass) begin
      raw_next = d_ext;
    end else begin
      case (mode)
        MODE_MASK:     raw_next = (m == '0) ? '0 : d_ext;
        MODE_INV_MASK: raw_next = (m != '0) ? '0 : d_ext;
        MODE_ADD:      raw_next = d_ext + m_ext;
        MODE_SUB:      raw_next = d_ext - m_ext;
        MODE_MUL:      raw_next = d_ext * m_ext;
        default:       raw_next = d_ext;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    raw <= raw_next;
  end

  // Second stage: clamp into the channel range.
  always_ff @(posedge clk) begin
    if (raw < 0) begin
      sat <= '0;
    end else if (raw > CH_MAX) begin
      sat <= CH_MAX[CHANNEL_BITS-1:0];
    end else begin
      sat <= raw[CHANNEL_BITS-1:0];
    end
  end

endmodule

/* verif/imc_result_check.sv */
`timescale 1ns / 1ps

module imc_result_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  imc_pkg::pix_in_t              pixel_in,
  input  logic                          result_valid,
  input  imc_pkg::pix_out_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [imc_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output int                            mismatch_count,
  output int                            pixels_in_flight
);
  import imc_pkg::*;

  // Local copy of the configuration registers, tracked from the bus.
  logic [MODE_BITS-1:0]       mode_q;
  logic                       color_q;
  logic [DIM_BITS-1:0]        dest_w_q;
  logic [DIM_BITS-1:0]        dest_h_q;
  logic [DIM_BITS-1:0]        mask_w_q;
  logic [DIM_BITS-1:0]        mask_h_q;
  logic signed [OFS_BITS-1:0] x_ofs_q;
  logic signed [OFS_BITS-1:0] y_ofs_q;

  // New pixels predicted for accepted transactions, oldest first.
  pix_out_t expected_pixels[$];
  pix_out_t want;

  // Combines one destination channel with its mask channel and saturates.
  function automatic logic [CHANNEL_BITS-1:0] combine_chan(
    input logic [MODE_BITS-1:0]    mode,
    input logic [CHANNEL_BITS-1:0] d,
    input logic [CHANNEL_BITS-1:0] m
  );
    int chan_max;
    int v;
    chan_max = (1 << CHANNEL_BITS) - 1;
    v = int'(d);
    case (mode)
      MODE_MASK:     if (m == '0) v = 0;
      MODE_INV_MASK: if (m != '0) v = 0;
      MODE_ADD:      v = v + int'(m);
      MODE_SUB:      v = v - int'(m);
      MODE_MUL:      v = v * int'(m);
      default:       ;
    endcase
    if (v < 0) v = 0;
    if (v > chan_max) v = chan_max;
    return CHANNEL_BITS'(v);
  endfunction

  // Works out the write flag, shifted position and new pixel for one transaction.
  function automatic pix_out_t blend_pixel(input pix_in_t p);
    pix_out_t r;
    int col;
    int row;
    int dcol;
    int drow;
    int coord_max;
    logic ok;
    coord_max = (1 << COORD_BITS) - 1;
    col  = int'(p.column);
    row  = int'(p.row);
    dcol = col + int'(x_ofs_q);
    drow = row + int'(y_ofs_q);
    ok = (col < int'(dest_w_q)) && (row < int'(dest_h_q)) &&
         (col < int'(mask_w_q)) && (row < int'(mask_h_q)) &&
         (dcol >= 0) && (drow >= 0) &&
         (dcol < int'(dest_w_q)) && (drow < int'(dest_h_q)) &&
         (dcol <= coord_max) && (drow <= coord_max);
    r = '0;
    if (ok) begin
      r.write_enable = 1'b1;
      r.dest_column  = COORD_BITS'(dcol);
      r.dest_row     = COORD_BITS'(drow);
      r.out_red      = combine_chan(mode_q, p.dest_red, p.mask_red);
      if (color_q) begin
        r.out_green = combine_chan(mode_q, p.dest_green, p.mask_green);
        r.out_blue  = combine_chan(mode_q, p.dest_blue, p.mask_blue);
      end else begin
        r.out_green = p.dest_green;
        r.out_blue  = p.dest_blue;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  // Track register writes, predict accepted transactions and compare results.
  always @(posedge clk) begin
    if (rst) begin
      mode_q   = MODE_MASK;
      color_q  = 1'b0;
      dest_w_q = DIM_RESET;
      dest_h_q = DIM_RESET;
      mask_w_q = DIM_RESET;
      mask_h_q = DIM_RESET;
      x_ofs_q  = '0;
      y_ofs_q  = '0;
      mismatch_count = 0;
      expected_pixels.delete();
    end else begin
      if (start && !busy) expected_pixels.push_back(blend_pixel(pixel_in));

      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_BITS-1:2])
          REG_COMBINE_MODE: mode_q   = pwdata[MODE_BITS-1:0];
          REG_COLOR_MODE:   color_q  = pwdata[0];
          REG_DEST_WIDTH:   dest_w_q = pwdata[DIM_BITS-1:0];
          REG_DEST_HEIGHT:  dest_h_q = pwdata[DIM_BITS-1:0];
          REG_MASK_WIDTH:   mask_w_q = pwdata[DIM_BITS-1:0];
          REG_MASK_HEIGHT:  mask_h_q = pwdata[DIM_BITS-1:0];
          REG_X_OFFSET:     x_ofs_q  = pwdata[OFS_BITS-1:0];
          REG_Y_OFFSET:     y_ofs_q  = pwdata[OFS_BITS-1:0];
          default:          ;
        endcase
      end

      if (result_valid) begin
        if (expected_pixels.size() == 0) begin
          $error("result transaction with nothing outstanding");
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("write_enable", 16'(want.write_enable), 16'(result.write_enable));
          check_field("dest_column", 16'(want.dest_column), 16'(result.dest_column));
          check_field("dest_row", 16'(want.dest_row), 16'(result.dest_row));
          check_field("out_red", 16'(want.out_red), 16'(result.out_red));
          check_field("out_green", 16'(want.out_green), 16'(result.out_green));
          check_field("out_blue", 16'(want.out_blue), 16'(result.out_blue));
        end
      end
    end
    pixels_in_flight = expected_pixels.size();
  end

endmodule

/* verif/image_mask_combine_test.sv */
`timescale 1ns / 1ps

module image_mask_combine_test;
  import imc_pkg::*;

  localparam int LATENCY     = 3;
  localparam int DRAIN_LIMIT = 200;
  localparam int NUM_PHASES  = 20;
  localparam int QUIET_TAIL  = 3;
  localparam int RGB_BITS    = 3 * CHANNEL_BITS;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int CHAN_MAX    = (1 << CHANNEL_BITS) - 1;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 start    = 1'b0;
  pix_in_t              pixel_in = '0;
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [ADDR_BITS-1:0] paddr    = '0;
  logic [31:0]          pwdata   = '0;

  logic      busy;
  logic      result_valid;
  pix_out_t  result;
  logic [31:0] prdata;
  logic      pready;

  int mismatch_count;
  int pixels_in_flight;
  int leftover_count = 0;

  // Configuration currently programmed, kept here to aim the coordinates.
  int cur_dw = 4096;
  int cur_dh = 4096;
  int cur_mw = 4096;
  int cur_mh = 4096;
  int cur_xo = 0;
  int cur_yo = 0;
  int idle_pct = 0;

  always #1 clk = ~clk;

  image_mask_combine u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .pixel_in     (pixel_in),
    .result_valid (result_valid),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  imc_result_check u_check (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .pixel_in         (pixel_in),
    .result_valid     (result_valid),
    .result           (result),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .mismatch_count   (mismatch_count),
    .pixels_in_flight (pixels_in_flight)
  );

  // APB write: setup cycle, then access until pready.
  task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_config(input int mode, input int color, input int dw, input int dh,
                              input int mw, input int mh, input int xo, input int yo);
    write_reg(REG_COMBINE_MODE, mode & 7);
    write_reg(REG_COLOR_MODE, color & 1);
    write_reg(REG_DEST_WIDTH, dw & 'h1FFF);
    write_reg(REG_DEST_HEIGHT, dh & 'h1FFF);
    write_reg(REG_MASK_WIDTH, mw & 'h1FFF);
    write_reg(REG_MASK_HEIGHT, mh & 'h1FFF);
    write_reg(REG_X_OFFSET, xo & 'h1FFF);
    write_reg(REG_Y_OFFSET, yo & 'h1FFF);
    cur_dw = dw;
    cur_dh = dh;
    cur_mw = mw;
    cur_mh = mh;
    cur_xo = xo;
    cur_yo = yo;
  endtask

  // Present one pixel pair and hold it until the block takes it; start stays high.
  task automatic send_pixel(input pix_in_t p);
    start    <= 1'b1;
    pixel_in <= p;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_fixed(input int col, input int row, input int drgb, input int mrgb);
    send_pixel({COORD_BITS'(col), COORD_BITS'(row), RGB_BITS'(drgb), RGB_BITS'(mrgb)});
  endtask

  // Random gap on the input side; the payload takes a random value while start is low.
  task automatic maybe_idle();
    if ($urandom_range(99) < idle_pct) begin
      start    <= 1'b0;
      pixel_in <= pix_in_t'({$urandom, $urandom, $urandom});
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Wait until every outstanding result has come back, then let the pipe settle.
  task automatic drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pixels_in_flight != 0 && waited < DRAIN_LIMIT);
    if (pixels_in_flight != 0) begin
      $error("%0d expected results never arrived", pixels_in_flight);
      leftover_count++;
    end
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Mostly inside the window that maps onto the destination, sometimes on its
  // edges, sometimes anywhere.
  function automatic logic [COORD_BITS-1:0] aim_coord(input int lo, input int hi);
    int sel;
    int v;
    sel = $urandom_range(99);
    if (sel < 15 || lo > hi) begin
      v = $urandom_range(COORD_MAX);
    end else if (sel < 35) begin
      case ($urandom_range(3))
        0:       v = lo;
        1:       v = hi;
        2:       v = lo - 1;
        default: v = hi + 1;
      endcase
    end else begin
      v = $urandom_range(lo, hi);
    end
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return COORD_BITS'(v);
  endfunction

  function automatic logic [CHANNEL_BITS-1:0] pick_chan();
    int sel;
    sel = $urandom_range(99);
    if (sel < 20) return '0;
    if (sel < 30) return CHANNEL_BITS'(CHAN_MAX);
    if (sel < 40) return CHANNEL_BITS'($urandom_range(1, 3));
    return CHANNEL_BITS'($urandom);
  endfunction

  function automatic pix_in_t make_pixel();
    pix_in_t p;
    int col_hi;
    int row_hi;
    col_hi = (cur_mw < cur_dw) ? cur_mw : cur_dw;
    if (cur_dw - cur_xo < col_hi) col_hi = cur_dw - cur_xo;
    row_hi = (cur_mh < cur_dh) ? cur_mh : cur_dh;
    if (cur_dh - cur_yo < row_hi) row_hi = cur_dh - cur_yo;
    if (col_hi > COORD_MAX + 1) col_hi = COORD_MAX + 1;
    if (row_hi > COORD_MAX + 1) row_hi = COORD_MAX + 1;
    p.column     = aim_coord((cur_xo < 0) ? -cur_xo : 0, col_hi - 1);
    p.row        = aim_coord((cur_yo < 0) ? -cur_yo : 0, row_hi - 1);
    p.dest_red   = pick_chan();
    p.dest_green = pick_chan();
    p.dest_blue  = pick_chan();
    p.mask_red   = pick_chan();
    p.mask_green = pick_chan();
    p.mask_blue  = pick_chan();
    return p;
  endfunction

  // Sizes lean to the extremes and small images; a few are zero or beyond range.
  function automatic int pick_dim();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return 1;
    if (sel < 20) return 4096;
    if (sel < 22) return 0;
    if (sel < 27) return $urandom_range(4097, 8191);
    if (sel < 60) return $urandom_range(1, 64);
    return $urandom_range(1, 4096);
  endfunction

  function automatic int pick_offset(input int span);
    int sel;
    int s;
    sel = $urandom_range(99);
    s = (span > 4095) ? 4095 : span;
    if (sel < 10) return -4095;
    if (sel < 20) return 4095;
    if (sel < 30) return 0;
    if (sel < 70) return $urandom_range(0, 2 * s) - s;
    return $urandom_range(0, 8190) - 4095;
  endfunction

  initial begin : stimulus
    int n;
    int mode;
    int dw;
    int dh;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: gray mask mode over full-size images.
    send_fixed(0, 0, 'hff00c8, 'h00ff64);
    send_fixed(4095, 4095, 'h0aff10, 'hc80111);

    // Every combine mode in RGB, the unused codes included: mask zero and
    // nonzero, add overflow, subtract underflow, multiply overflow.
    for (int m = 0; m < 8; m++) begin
      drain();
      apply_config(m, 1, 4096, 4096, 4096, 4096, 0, 0);
      send_fixed(0, 0, 'hff00c8, 'h00ff64);
      send_fixed(4095, 4095, 'h0aff10, 'hc80111);
    end

    // A zero destination width leaves no valid position.
    drain();
    apply_config(MODE_ADD, 1, 0, 4096, 4096, 4096, 0, 0);
    send_fixed(0, 0, 'h102030, 'h010203);

    // Oversized images: a shift past the coordinate range is invalid.
    drain();
    apply_config(MODE_SUB, 1, 8191, 8191, 8191, 8191, 4095, 4095);
    send_fixed(4095, 0, 'h808080, 'h010101);
    send_fixed(0, 0, 'h808080, 'hff0001);

    // Largest negative shift: the far corner lands on the origin.
    drain();
    apply_config(MODE_MUL, 0, 4096, 4096, 4096, 4096, -4095, -4095);
    send_fixed(4095, 4095, 'h11ff22, 'h10ff03);
    send_fixed(0, 0, 'h11ff22, 'h10ff03);

    // Random phases, each under a fresh configuration.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      mode = ($urandom_range(99) < 85) ? $urandom_range(0, 4) : $urandom_range(5, 7);
      dw = pick_dim();
      dh = pick_dim();
      apply_config(mode, $urandom_range(1), dw, dh, pick_dim(), pick_dim(),
                   pick_offset(dw), pick_offset(dh));
      case ($urandom_range(2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 30;
      endcase
      if (ph >= NUM_PHASES - QUIET_TAIL) idle_pct = 0;
      n = $urandom_range(50, 90);
      for (int i = 0; i < n; i++) begin
        maybe_idle();
        send_pixel(make_pixel());
      end
    end
    drain();

    if (mismatch_count == 0 && leftover_count == 0) begin
      $display("image_mask_combine test passed");
    end else begin
      $display("image_mask_combine test failed");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #1000000;
    $display("image_mask_combine test failed");
    $finish;
  end

endmodule
